[design/scta_pkg.sv]
// shared types, key codes and set-1 character tables for the scancode decoder
// no dependencies
package scta_pkg;

    localparam logic [7:0] KEY_RELEASE_BIT = 8'h80;
    localparam logic [7:0] KEY_CODE_MASK   = 8'h7f;
    localparam logic [7:0] KEY_LSHIFT      = 8'h2a;
    localparam logic [7:0] KEY_RSHIFT      = 8'h36;
    localparam logic [7:0] KEY_CAPS        = 8'h3a;
    localparam logic [7:0] KEY_TABLE_LEN   = 8'd58;

    localparam int CHAR_W = 7;

    typedef struct packed {
        logic              req;
        logic [CHAR_W-1:0] data;
    } push_t;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic              read_valid;
        logic              char_available;
        logic              dropped;
    } result_t;

    function automatic logic [CHAR_W-1:0] lower_char(input logic [5:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            6'd2:  ch = 7'h31;  6'd3:  ch = 7'h32;  6'd4:  ch = 7'h33;  6'd5:  ch = 7'h34;
            6'd6:  ch = 7'h35;  6'd7:  ch = 7'h36;  6'd8:  ch = 7'h37;  6'd9:  ch = 7'h38;
            6'd10: ch = 7'h39;  6'd11: ch = 7'h30;  6'd12: ch = 7'h2d;  6'd13: ch = 7'h3d;
            6'd14: ch = 7'h08;  6'd15: ch = 7'h09;  6'd16: ch = 7'h71;  6'd17: ch = 7'h77;
            6'd18: ch = 7'h65;  6'd19: ch = 7'h72;  6'd20: ch = 7'h74;  6'd21: ch = 7'h79;
            6'd22: ch = 7'h75;  6'd23: ch = 7'h69;  6'd24: ch = 7'h6f;  6'd25: ch = 7'h70;
            6'd26: ch = 7'h5b;  6'd27: ch = 7'h5d;  6'd28: ch = 7'h0a;  6'd30: ch = 7'h61;
            6'd31: ch = 7'h73;  6'd32: ch = 7'h64;  6'd33: ch = 7'h66;  6'd34: ch = 7'h67;
            6'd35: ch = 7'h68;  6'd36: ch = 7'h6a;  6'd37: ch = 7'h6b;  6'd38: ch = 7'h6c;
            6'd39: ch = 7'h3b;  6'd40: ch = 7'h27;  6'd41: ch = 7'h60;  6'd43: ch = 7'h5c;
            6'd44: ch = 7'h7a;  6'd45: ch = 7'h78;  6'd46: ch = 7'h63;  6'd47: ch = 7'h76;
            6'd48: ch = 7'h62;  6'd49: ch = 7'h6e;  6'd50: ch = 7'h6d;  6'd51: ch = 7'h2c;
            6'd52: ch = 7'h2e;  6'd53: ch = 7'h2f;  6'd55: ch = 7'h2a;  6'd57: ch = 7'h20;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] upper_char(input logic [5:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            6'd2:  ch = 7'h21;  6'd3:  ch = 7'h40;  6'd4:  ch = 7'h23;  6'd5:  ch = 7'h24;
            6'd6:  ch = 7'h25;  6'd7:  ch = 7'h5e;  6'd8:  ch = 7'h26;  6'd9:  ch = 7'h2a;
            6'd10: ch = 7'h28;  6'd11: ch = 7'h29;  6'd12: ch = 7'h5f;  6'd13: ch = 7'h2b;
            6'd14: ch = 7'h08;  6'd15: ch = 7'h09;  6'd16: ch = 7'h51;  6'd17: ch = 7'h57;
            6'd18: ch = 7'h45;  6'd19: ch = 7'h52;  6'd20: ch = 7'h54;  6'd21: ch = 7'h59;
            6'd22: ch = 7'h55;  6'd23: ch = 7'h49;  6'd24: ch = 7'h4f;  6'd25: ch = 7'h50;
            6'd26: ch = 7'h7b;  6'd27: ch = 7'h7d;  6'd28: ch = 7'h0a;  6'd30: ch = 7'h41;
            6'd31: ch = 7'h53;  6'd32: ch = 7'h44;  6'd33: ch = 7'h46;  6'd34: ch = 7'h47;
            6'd35: ch = 7'h48;  6'd36: ch = 7'h4a;  6'd37: ch = 7'h4b;  6'd38: ch = 7'h4c;
            6'd39: ch = 7'h3a;  6'd40: ch = 7'h22;  6'd41: ch = 7'h7e;  6'd43: ch = 7'h7c;
            6'd44: ch = 7'h5a;  6'd45: ch = 7'h58;  6'd46: ch = 7'h43;  6'd47: ch = 7'h56;
            6'd48: ch = 7'h42;  6'd49: ch = 7'h4e;  6'd50: ch = 7'h4d;  6'd51: ch = 7'h3c;
            6'd52: ch = 7'h3e;  6'd53: ch = 7'h3f;  6'd55: ch = 7'h2a;  6'd57: ch = 7'h20;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

[design/scta_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module scta_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/scta_decode.sv]
// set-1 scancode decoder: shift and caps lock state, character table lookup
// depends on scta_pkg
module scta_decode
    import scta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan_beat,
    input  logic [7:0] scan_byte,
    output push_t      push
);

    logic       shift_reg, shift_next;
    logic       caps_reg, caps_next;
    logic [7:0] key;
    logic [CHAR_W-1:0] ch;

    assign key = scan_byte & KEY_CODE_MASK;

    always_comb
    begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        push.req   = 1'b0;
        ch         = (shift_reg != caps_reg) ? upper_char(scan_byte[5:0])
                                             : lower_char(scan_byte[5:0]);
        push.data  = ch;
        if (scan_beat)
        begin
            if ((scan_byte & KEY_RELEASE_BIT) != 8'h00)
            begin
                if (key == KEY_LSHIFT || key == KEY_RSHIFT)
                begin
                    shift_next = 1'b0;
                end
            end
            else if (scan_byte == KEY_LSHIFT || scan_byte == KEY_RSHIFT)
            begin
                shift_next = 1'b1;
            end
            else if (scan_byte == KEY_CAPS)
            begin
                caps_next = !caps_reg;
            end
            else if (scan_byte < KEY_TABLE_LEN)
            begin
                push.req = (ch != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

[design/scta_char_fifo.sv]
// ring fifo of characters holding FIFO_DEPTH-1 entries, head prefetched from ram
// depends on scta_pkg and scta_ram
module scta_char_fifo
    import scta_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    input  logic              pop_req,
    output logic [CHAR_W-1:0] head,
    output logic              popped,
    output logic              dropped,
    output logic              avail
);

    localparam int IDX_W = $clog2(FIFO_DEPTH);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(FIFO_DEPTH - 1);

    logic [IDX_W-1:0]  wr_reg, wr_next, wr_inc;
    logic [IDX_W-1:0]  rd_reg, rd_next, rd_inc;
    logic              empty, full, do_push;
    logic              bypass_valid_reg, bypass_valid_next;
    logic [CHAR_W-1:0] bypass_data_reg;
    logic [CHAR_W-1:0] ram_rdata;

    always_comb
    begin
        wr_inc  = (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
        rd_inc  = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
        empty   = (rd_reg == wr_reg);
        full    = (wr_inc == rd_reg);
        popped  = pop_req && !empty;
        do_push = push.req && !full;
        dropped = push.req && full;
        wr_next = do_push ? wr_inc : wr_reg;
        rd_next = popped ? rd_inc : rd_reg;
        avail   = (rd_next != wr_next);
        // ram read of the new head misses a write to that same slot this cycle
        bypass_valid_next = do_push && (wr_reg == rd_next);
        head    = bypass_valid_reg ? bypass_data_reg : ram_rdata;
    end

    scta_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_reg),
        .wdata (push.data),
        .raddr (rd_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg           <= '0;
            rd_reg           <= '0;
            bypass_valid_reg <= 1'b0;
        end
        else
        begin
            wr_reg           <= wr_next;
            rd_reg           <= rd_next;
            bypass_valid_reg <= bypass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_data_reg <= push.data;
    end

endmodule

[design/scta_out_skid.sv]
// output register with a skid entry, stall toward the input is registered
// depends on scta_pkg
module scta_out_skid
    import scta_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_beat,
    input  result_t in_data,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    take;

    assign take      = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_beat)
            begin
                out_data_next = in_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_beat)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

[design/scancode_to_ascii_fifo.sv]
// top level: set-1 scancode to ascii decoder with character fifo
// depends on scta_pkg, scta_decode, scta_char_fifo, scta_ram, scta_out_skid
//
// Each input beat is either a raw set-1 scancode (action 0) or a request to read one
// character (action 1), and every beat yields exactly one result beat. One beat is
// accepted per clock while in_stall is low; its result is registered in the output
// register, or in the skid entry behind a stalled result. The decode, the fifo
// pointer update and the head selection all settle in the accepting cycle, with the
// fifo head prefetched from the registered-read ram. A skid entry behind the output
// register lets one more beat in while a result is stalled; in_stall rises only when
// that entry is occupied. A read on an empty fifo returns read_valid 0, and a character
// that finds the fifo full (FIFO_DEPTH-1 entries) is discarded and flagged by dropped.
module scancode_to_ascii_fifo
    import scta_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] scan_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] read_char,
    output logic       read_valid,
    output logic       char_available,
    output logic       dropped
);

    logic              accept;
    push_t             push;
    logic [CHAR_W-1:0] head;
    logic              popped, lost, avail;
    result_t           result, out_data;

    assign accept = in_valid && !in_stall;

    scta_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_beat (accept && !action),
        .scan_byte (scan_byte),
        .push      (push)
    );

    scta_char_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop_req (accept && action),
        .head    (head),
        .popped  (popped),
        .dropped (lost),
        .avail   (avail)
    );

    always_comb
    begin
        result.read_char      = popped ? head : '0;
        result.read_valid     = popped;
        result.char_available = avail;
        result.dropped        = lost;
    end

    scta_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (accept),
        .in_data   (result),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign read_char      = out_data.read_char;
    assign read_valid     = out_data.read_valid;
    assign char_available = out_data.char_available;
    assign dropped        = out_data.dropped;

    // skid entry is only used behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("skid entry occupied with empty output register");

    // a beat that meets a stalled result has to land in the skid entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && accept) |=> in_stall)
        else $error("beat accepted behind stalled result was not held");

    // a read never drops, and every popped character is nonzero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_valid) |-> (!dropped && read_char != 7'h00))
        else $error("bad read result");

endmodule
